>>> rtl/neighbor_mask_autotile_core_defines.svh
// Assertion macros shared by the checker of the neighbor mask autotile core
`ifndef NEIGHBOR_MASK_AUTOTILE_CORE_DEFINES_SVH
`define NEIGHBOR_MASK_AUTOTILE_CORE_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define NMA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: property failed");

// next-cycle implication, held off while reset is low
`define NMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: property failed");

`endif

>>> rtl/nma_pkg.sv
// Types and constants shared by the neighbor mask autotile modules
`default_nettype none
package nma_pkg;

    localparam int COL_W = 6;
    localparam int ROW_W = 6;
    localparam int LAYER_W = 1;
    localparam int MAT_W = 2;
    localparam int TILE_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int GRID_W = 7;
    localparam int FLAGS_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_THREE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS       = 3'd5;

    // register reset values
    localparam logic [GRID_W-1:0]  RST_GRID_WIDTH  = 7'd16;
    localparam logic [GRID_W-1:0]  RST_GRID_HEIGHT = 7'd16;
    localparam logic [TILE_W-1:0]  RST_FIRST_ONE   = 8'd0;
    localparam logic [TILE_W-1:0]  RST_FIRST_TWO   = 8'd16;
    localparam logic [TILE_W-1:0]  RST_FIRST_THREE = 8'd32;
    localparam logic [FLAGS_W-1:0] RST_FLAGS       = 3'd7;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [MAT_W-1:0] MAT_EMPTY = 2'd0;
    localparam logic [MAT_W-1:0] MAT_ONE   = 2'd1;
    localparam logic [MAT_W-1:0] MAT_TWO   = 2'd2;
    localparam logic [MAT_W-1:0] MAT_THREE = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DONE
    } t_state;

    // fetch order of one read: center, then up, right, down, left
    typedef enum logic [2:0] {
        STEP_CENTER,
        STEP_UP,
        STEP_RIGHT,
        STEP_DOWN,
        STEP_LEFT
    } t_step;

    typedef struct packed {
        logic  clear;
        logic  wr;
        logic  load;
        logic  fetch;
        t_step step;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic beat_read;
        logic beat_inside;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/nma_ctrl.sv
// Sequencer of the autotile core: clearing pass, beat intake, neighbor fetches
`default_nettype none
module nma_ctrl
    import nma_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_valid,
    output logic         o_s_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= STEP_CENTER;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_step         = r_step;
        o_s_ready      = 1'b0;
        o_cmd.clear    = 1'b0;
        o_cmd.wr       = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.fetch    = 1'b0;
        o_cmd.step     = r_step;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    if (i_status.beat_read) begin
                        o_cmd.load = 1'b1;
                        n_step     = STEP_CENTER;
                        // skip the fetches for a read outside the grid
                        n_state    = i_status.beat_inside ? S_FETCH : S_DONE;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                if (r_step == STEP_LEFT) begin
                    n_state = S_DONE;
                end else begin
                    n_step = t_step'(r_step + 3'd1);
                end
            end
            S_DONE: begin
                // hold until the output register can take the beat
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/nma_datapath.sv
// Datapath of the autotile core: registers, cell store, neighbor compare, output
`default_nettype none
module nma_datapath
    import nma_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int LAYERS     = 2,
    parameter int MATERIALS  = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_kind,
    input  wire logic [COL_W-1:0]      i_column,
    input  wire logic [ROW_W-1:0]      i_row,
    input  wire logic [LAYER_W-1:0]    i_layer,
    input  wire logic [MAT_W-1:0]      i_material,
    input  wire logic                  i_m_ready,
    output logic                       o_m_valid,
    output logic [TILE_W-1:0]          o_m_tile,
    output logic                       o_m_bad
);

    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT * LAYERS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > GRID_W) ? $clog2(MAX_WIDTH + 1) : GRID_W;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > GRID_W) ? $clog2(MAX_HEIGHT + 1) : GRID_W;

    // configuration
    logic [GRID_W-1:0]  r_grid_width;
    logic [GRID_W-1:0]  r_grid_height;
    logic [TILE_W-1:0]  r_first_one;
    logic [TILE_W-1:0]  r_first_two;
    logic [TILE_W-1:0]  r_first_three;
    logic [FLAGS_W-1:0] r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_first_one   <= RST_FIRST_ONE;
            r_first_two   <= RST_FIRST_TWO;
            r_first_three <= RST_FIRST_THREE;
            r_flags       <= RST_FLAGS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GRID_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GRID_W-1:0];
                CFG_FIRST_ONE:   r_first_one   <= i_cfg_data;
                CFG_FIRST_TWO:   r_first_two   <= i_cfg_data;
                CFG_FIRST_THREE: r_first_three <= i_cfg_data;
                CFG_FLAGS:       r_flags       <= i_cfg_data[FLAGS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp the grid size to the store
    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    assign eff_w = (WW'(r_grid_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_grid_width);
    assign eff_h = (HW'(r_grid_height) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT)
                                                          : HW'(r_grid_height);

    logic          beat_inside;
    logic          mat_ok;
    logic [AW-1:0] beat_addr;

    assign beat_inside = (WW'(i_column) < eff_w) && (HW'(i_row) < eff_h)
                         && (int'(i_layer) < LAYERS);
    assign mat_ok      = int'(i_material) <= MATERIALS;
    assign beat_addr   = AW'((int'(i_layer) * MAX_HEIGHT + int'(i_row)) * MAX_WIDTH
                             + int'(i_column));

    // item under read
    logic [AW-1:0]    r_base;
    logic [COL_W-1:0] r_x;
    logic [ROW_W-1:0] r_y;
    logic             r_bad;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= beat_addr;
            r_x    <= i_column;
            r_y    <= i_row;
            r_bad  <= !beat_inside;
        end
    end

    logic up_ok, right_ok, down_ok, left_ok;
    assign up_ok    = r_y != '0;
    assign left_ok  = r_x != '0;
    assign down_ok  = (HW'(r_y) + HW'(1)) < eff_h;
    assign right_ok = (WW'(r_x) + WW'(1)) < eff_w;

    logic [AW-1:0] fetch_addr;
    always_comb begin
        unique case (i_cmd.step)
            STEP_CENTER: fetch_addr = r_base;
            STEP_UP:     fetch_addr = up_ok    ? r_base - AW'(MAX_WIDTH) : r_base;
            STEP_RIGHT:  fetch_addr = right_ok ? r_base + AW'(1)         : r_base;
            STEP_DOWN:   fetch_addr = down_ok  ? r_base + AW'(MAX_WIDTH) : r_base;
            STEP_LEFT:   fetch_addr = left_ok  ? r_base - AW'(1)         : r_base;
            default:     fetch_addr = r_base;
        endcase
    end

    // clearing pass counter
    logic [AW-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // single-port cell store
    logic [MAT_W-1:0] mem [CELL_COUNT];
    logic [MAT_W-1:0] r_rd_data;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;
    logic [MAT_W-1:0] mem_wdata;

    always_comb begin
        priority if (i_cmd.clear) begin
            mem_addr = r_clr_addr;
        end else if (i_cmd.wr) begin
            mem_addr = beat_addr;
        end else begin
            mem_addr = fetch_addr;
        end
    end

    assign mem_we    = i_cmd.clear || (i_cmd.wr && beat_inside && mat_ok);
    assign mem_wdata = i_cmd.clear ? MAT_EMPTY : i_material;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else if (i_cmd.fetch) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    // capture center, up, right and down; left stays in the read register
    logic             r_fetch_vld;
    t_step            r_fetch_step;
    logic [2:0]       fetch_code;
    logic [MAT_W-1:0] r_cell [4];

    assign fetch_code = r_fetch_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch_vld <= 1'b0;
        end else begin
            r_fetch_vld <= i_cmd.fetch;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fetch_step <= i_cmd.step;
        if (r_fetch_vld && r_fetch_step != STEP_LEFT) begin
            r_cell[fetch_code[1:0]] <= r_rd_data;
        end
    end

    logic [MAT_W-1:0]  cur;
    logic [MAT_W-1:0]  nb_up, nb_right, nb_down, nb_left;
    logic [3:0]        edge_mask;
    logic [TILE_W-1:0] first_index;
    logic              autotile;
    logic [TILE_W-1:0] tile;

    assign cur      = r_cell[0];
    assign nb_up    = up_ok    ? r_cell[1] : MAT_EMPTY;
    assign nb_right = right_ok ? r_cell[2] : MAT_EMPTY;
    assign nb_down  = down_ok  ? r_cell[3] : MAT_EMPTY;
    assign nb_left  = left_ok  ? r_rd_data : MAT_EMPTY;

    // weights 8, 4, 2, 1: a set bit is a neighbor that differs
    assign edge_mask = {nb_up != cur, nb_right != cur, nb_down != cur, nb_left != cur};

    always_comb begin
        unique case (cur)
            MAT_ONE: begin
                first_index = r_first_one;
                autotile    = r_flags[0];
            end
            MAT_TWO: begin
                first_index = r_first_two;
                autotile    = r_flags[1];
            end
            MAT_THREE: begin
                first_index = r_first_three;
                autotile    = r_flags[2];
            end
            default: begin
                first_index = '0;
                autotile    = 1'b0;
            end
        endcase
    end

    assign tile = (cur == MAT_EMPTY) ? '0
                : first_index + TILE_W'(1) + (autotile ? TILE_W'(edge_mask) : '0);

    // output register
    logic              r_out_valid;
    logic [TILE_W-1:0] r_out_tile;
    logic              r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_tile <= r_bad ? '0 : tile;
            r_out_bad  <= r_bad;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_tile  = r_out_tile;
    assign o_m_bad   = r_out_bad;

    assign o_status.clear_last  = r_clr_addr == AW'(CELL_COUNT - 1);
    assign o_status.beat_read   = i_kind == KIND_READ;
    assign o_status.beat_inside = beat_inside;
    assign o_status.out_free    = !r_out_valid || i_m_ready;

endmodule
`default_nettype wire

>>> rtl/neighbor_mask_autotile_core.sv
// Top level of the four-neighbor bitmask autotile core
//
//  channel   direction  signals                         beat contents
//  s_axis    in         tvalid tready tdata[15:0] tuser  write or read of one cell
//  m_axis    out        tvalid tready tdata[7:0] tuser   tile index of one read
//  cfg       in         we index[2:0] data[7:0]          register write, no read-back
//
//  A write beat goes to the store at intake; an in-grid read runs intake, five fetches
//  (cell, up, right, down, left) through the single port of the cell store, and
//  the result load. A read outside the grid runs intake and the result load only.
//  After reset a clearing pass zeroes the store, one cell a cycle, all
//  MAX_WIDTH*MAX_HEIGHT*LAYERS cells (8192 at the defaults); s_axis stays not ready,
//  configuration writes are taken throughout.
//  A result waiting in the output register holds the next read at its last step.
`default_nettype none
module neighbor_mask_autotile_core
    import nma_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int LAYERS     = 2,
    parameter int MATERIALS  = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // column[5:0], row[11:6], layer[12], material[14:13], zero[15]
    input  wire logic [15:0]           i_s_axis_tdata,
    // kind[0]
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tile_index[7:0]
    output logic [TILE_W-1:0]          o_m_axis_tdata,
    // bad_coordinate[0]
    output logic                       o_m_axis_tuser,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    nma_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(i_s_axis_tvalid),
        .o_s_ready(o_s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nma_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .LAYERS    (LAYERS),
        .MATERIALS (MATERIALS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_s_axis_tuser),
        .i_column   (i_s_axis_tdata[5:0]),
        .i_row      (i_s_axis_tdata[11:6]),
        .i_layer    (i_s_axis_tdata[12]),
        .i_material (i_s_axis_tdata[14:13]),
        .i_m_ready  (i_m_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .o_m_tile   (o_m_axis_tdata),
        .o_m_bad    (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

>>> rtl/nma_checker.sv
// Port-level checks of the autotile core and their bind to the top level
`default_nettype none
`include "neighbor_mask_autotile_core_defines.svh"
module nma_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic       i_s_axis_tuser,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tuser
);

    logic in_beat;
    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;

    logic       out_wait;
    logic [8:0] out_word;
    assign out_wait = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word = {o_m_axis_tuser, o_m_axis_tdata};

    // a flagged read carries tile index zero
    `NMA_ASSERT_NOW(a_bad_is_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == 8'd0)

    // a stalled result beat holds
    `NMA_ASSERT_NEXT(a_out_hold, out_wait, o_m_axis_tvalid && $stable(out_word))

    // a read occupies the block past its intake cycle
    `NMA_ASSERT_NEXT(a_read_busy, in_beat && i_s_axis_tuser, !o_s_axis_tready)

    // a write finishes in its intake cycle
    `NMA_ASSERT_NEXT(a_write_fast, in_beat && !i_s_axis_tuser, o_s_axis_tready)

endmodule

bind neighbor_mask_autotile_core nma_checker u_nma_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_s_axis_tvalid(i_s_axis_tvalid),
    .o_s_axis_tready(o_s_axis_tready),
    .i_s_axis_tuser (i_s_axis_tuser),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
`default_nettype wire
